@@ rtl/core/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 4;
    localparam int ST_W         = 2;
    localparam int DEF_CAPACITY = 8;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic        [ST_W-1:0]   status;
        logic signed [DATA_W-1:0] removed_value;
        logic        [OCC_W-1:0]  occupancy;
    } t_out_beat;

endpackage

@@ rtl/core/sorted_array_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top
// Ascending priority queue of signed values kept sorted in a small memory.
//
//   channel   direction   handshake                 beat
//   in        input       i_in_valid / o_in_stall   t_in_beat (req_type, value)
//   out       output      o_out_valid / i_out_stall t_out_beat (status,
//                                                   removed_value, occupancy)
//
// With the output register free, an insert into an empty queue and a full or
// empty reject go straight to the result; any other insert walks down past the
// entries at or above the new value, and a remove shifts every entry left behind
// down one place. One entry moves per cycle through the single memory read and
// write port. One item is in the sequencer at a time; a finished result waits in
// the output register while the next beat is taken.
// Reset clears the count and the control state; memory contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_top
    import sapq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic      res_valid;
    logic      res_take;
    t_out_beat res;

    logic      r_out_valid;
    t_out_beat r_out_beat;

    sapq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_beat <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

@@ rtl/core/sapq_seq.sv @@
// ----------------------------------------------------------------------------
// sapq_seq
// Sequencer around the entry memory: searches and shifts one entry per cycle
// through a one-read, one-write synchronous memory, then offers the result.
// ----------------------------------------------------------------------------
module sapq_seq
    import sapq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_res_valid,
    input  logic      i_res_take,
    output t_out_beat o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_REM0 = 3'd3;
    localparam logic [2:0] S_REM  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_k, n_k;
    logic signed [DATA_W-1:0] r_v, n_v;
    t_out_beat                r_res, n_res;
    logic signed [DATA_W-1:0] r_rdata;

    logic              mem_we, mem_re;
    logic [CW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              rd_lt_v;

    assign rd_lt_v     = r_rdata < r_v;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_v       = r_v;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_v;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.status        = ST_OK;
                    n_res.removed_value = '0;
                    n_res.occupancy     = OCC_W'(r_count);
                    n_v                 = i_in_beat.value;
                    if (i_in_beat.req_type == REQ_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            mem_we          = 1'b1;
                            mem_wdata       = i_in_beat.value;
                            n_count         = CW'(1);
                            n_res.occupancy = OCC_W'(CW'(1));
                            n_state         = S_DONE;
                        end else begin
                            // walk down from the top entry
                            mem_re    = 1'b1;
                            mem_raddr = r_count - CW'(1);
                            n_k       = r_count;
                            n_state   = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            mem_re  = 1'b1;
                            n_state = S_REM0;
                        end
                    end
                end
            end
            S_INS: begin
                // r_rdata holds entry r_k-1
                mem_we    = 1'b1;
                mem_waddr = r_k;
                if (rd_lt_v) begin
                    mem_wdata       = r_v;
                    n_count         = r_count + CW'(1);
                    n_res.occupancy = OCC_W'(r_count + CW'(1));
                    n_state         = S_DONE;
                end else begin
                    mem_wdata = r_rdata;
                    n_k       = r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_k - CW'(2);
                    end
                end
            end
            S_PUT: begin
                mem_we          = 1'b1;
                mem_waddr       = r_k;
                mem_wdata       = r_v;
                n_count         = r_count + CW'(1);
                n_res.occupancy = OCC_W'(r_count + CW'(1));
                n_state         = S_DONE;
            end
            S_REM0: begin
                n_res.removed_value = r_rdata;
                if (r_count == CW'(1)) begin
                    n_count         = '0;
                    n_res.occupancy = '0;
                    n_state         = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = CW'(1);
                    n_k       = CW'(1);
                    n_state   = S_REM;
                end
            end
            S_REM: begin
                // move entry r_k down one place
                mem_we    = 1'b1;
                mem_waddr = r_k - CW'(1);
                mem_wdata = r_rdata;
                if (r_k + CW'(1) == r_count) begin
                    n_count         = r_count - CW'(1);
                    n_res.occupancy = OCC_W'(r_count - CW'(1));
                    n_state         = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k + CW'(1);
                    n_k       = r_k + CW'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_v   <= n_v;
        r_res <= n_res;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == ST_FULL) |-> r_count == CW'(CAPACITY))
        else $error("full status with free entries");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == ST_EMPTY)
            |-> (r_count == '0 && r_res.removed_value == '0))
        else $error("empty status with stored entries");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> mem_waddr < CW'(CAPACITY))
        else $error("memory write beyond capacity");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_res_take) |=> (r_state == S_DONE && $stable(r_res)))
        else $error("pending result changed");
`endif

endmodule

@@ verif/sapq_checker.sv @@
// ----------------------------------------------------------------------------
// sapq_checker
// Watches both channels of the sorted-array priority queue. It keeps its own
// sorted copy of the store, works out the reply to every accepted request,
// and compares each accepted reply with the oldest one still due.
// ----------------------------------------------------------------------------
module sapq_checker
    import sapq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_fail_count,
    output int        o_replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [DATA_W-1:0] model_entries [CAPACITY];
    int                       model_count;
    t_out_beat                replies_due [$];
    int                       mismatches;

    initial begin
        o_fail_count  = 0;
        o_replies_due = 0;
        mismatches    = 0;
        model_count   = 0;
    end

    // Apply one request to the sorted copy and return the reply it causes.
    function automatic t_out_beat apply_request(t_in_beat req);
        t_out_beat reply;
        int        pos;
        reply.status        = ST_OK;
        reply.removed_value = '0;
        if (req.req_type == REQ_INSERT) begin
            if (model_count >= CAPACITY) begin
                reply.status = ST_FULL;
            end else begin
                pos = 0;
                // land ahead of equal values
                while (pos < model_count && model_entries[pos] < req.value)
                    pos++;
                for (int k = model_count; k > pos; k--)
                    model_entries[k] = model_entries[k-1];
                model_entries[pos] = req.value;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                reply.status = ST_EMPTY;
            end else begin
                reply.removed_value = model_entries[0];
                for (int k = 1; k < model_count; k++)
                    model_entries[k-1] = model_entries[k];
                model_count--;
            end
        end
        reply.occupancy = OCC_W'(model_count);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            model_count = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("reply beat with no request outstanding");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_beat.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_out_beat.status);
                        mismatches++;
                    end
                    if (i_out_beat.removed_value !== want.removed_value) begin
                        $error("removed_value mismatch: expected %0d, got %0d",
                               want.removed_value, i_out_beat.removed_value);
                        mismatches++;
                    end
                    if (i_out_beat.occupancy !== want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, got %0d",
                               want.occupancy, i_out_beat.occupancy);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                replies_due.push_back(apply_request(i_in_beat));
        end
        o_fail_count  <= mismatches;
        o_replies_due <= replies_due.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sorted-array priority queue: a directed pass over empty,
// full, extreme and equal values, then random insert/remove traffic in
// segments that lean toward filling or draining, with bursty requests and
// a receiver that stalls in patterns, including a long hold-off now and then.
// ----------------------------------------------------------------------------
module tb_top;
    import sapq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = DEF_CAPACITY;
    localparam int RANDOM_BEATS = 1730;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;
    int        fail_count;
    int        replies_due;

    sorted_array_priority_queue_top #(.CAPACITY(CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    sapq_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_beat     (i_in_beat),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_beat    (o_out_beat),
        .o_fail_count  (fail_count),
        .o_replies_due (replies_due)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one beat and hold it until accepted.
    task automatic send_beat(input logic req, input logic signed [DATA_W-1:0] val);
        i_in_valid <= 1'b1;
        i_in_beat  <= '{req_type: req, value: val};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop valid and wait until every reply has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0) @(posedge i_clk);
    endtask

    // Mix of narrow range (many equal values), extremes and full range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return DATA_W'($signed($urandom_range(0, 6)) - 3);
        if (sel < 35) begin
            case ($urandom_range(0, 5))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_MIN + 1;
                3:       return VAL_MAX - 1;
                4:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Receiver: stall patterns of random length, with a long hold now and then.
    initial begin
        int mode_idx;
        int mode;
        int span;
        mode_idx = 0;
        forever begin
            if (mode_idx % 6 == 2) begin
                mode = 3;
                span = $urandom_range(200, 400);
            end else begin
                mode = $urandom_range(0, 4);
                if (mode == 3) mode = 0;
                span = $urandom_range(10, 100);
            end
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_out_stall <= ($urandom_range(0, 99) < 70);
                    3:       i_out_stall <= 1'b1;
                    default: i_out_stall <= k[0];
                endcase
            end
            mode_idx++;
        end
    end

    initial begin
        int insert_pct;
        int seg_left;
        int burst_left;
        logic req;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty remove, extremes, equal values, fill, full, drain
        send_beat(REQ_REMOVE, 32'sd77);
        send_beat(REQ_INSERT, 32'sd0);
        send_beat(REQ_INSERT, VAL_MAX);
        send_beat(REQ_INSERT, VAL_MIN);
        send_beat(REQ_INSERT, -32'sd1);
        send_beat(REQ_INSERT, 32'sd0);
        send_beat(REQ_INSERT, 32'sd1);
        send_beat(REQ_INSERT, VAL_MIN);
        send_beat(REQ_INSERT, 32'sd5);
        send_beat(REQ_INSERT, 32'sd3);
        send_beat(REQ_INSERT, VAL_MIN);
        for (int k = 0; k < CAP; k++)
            send_beat(REQ_REMOVE, '1);
        send_beat(REQ_REMOVE, '0);
        send_beat(REQ_INSERT, VAL_MAX);
        send_beat(REQ_REMOVE, '0);
        wait_drained();

        seg_left   = 0;
        burst_left = 0;
        insert_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 15;
                    1:       insert_pct = 85;
                    2:       insert_pct = 60;
                    default: insert_pct = 50;
                endcase
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            if (burst_left == 0) begin
                // no gap on a quarter of the bursts
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (n == RANDOM_BEATS / 2)
                wait_drained();
            req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
            send_beat(req, pick_value());
        end

        wait_drained();
        repeat (CAP + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sapq_pkg.sv
rtl/core/sapq_seq.sv
rtl/core/sorted_array_priority_queue_top.sv
verif/sapq_checker.sv
verif/tb_top.sv
